### rtl/core/sfce_pkg.sv
// shared types, constants and helpers for the serial fram command engine
`timescale 1ns / 1ps
package sfce_pkg;

    localparam int ADDR_BITS = 16;
    localparam int ID_LENGTH = 9;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 64;

    // item modes
    localparam logic [1:0] MODE_CS_ASSERT = 2'd0;
    localparam logic [1:0] MODE_XFER = 2'd1;
    localparam logic [1:0] MODE_CS_RELEASE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ID_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_LAST = 1'b1;

    // opcodes
    localparam logic [7:0] OP_WRSR = 8'h01;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_READ = 8'h03;
    localparam logic [7:0] OP_WRDI = 8'h04;
    localparam logic [7:0] OP_RDSR = 8'h05;
    localparam logic [7:0] OP_WREN = 8'h06;
    localparam logic [7:0] OP_RDID = 8'h9F;
    localparam logic [7:0] OP_SLEEP = 8'hB9;

    localparam logic [7:0] STATUS_MASK = 8'h8C;
    localparam logic [7:0] IDLE_BYTE = 8'hFF;
    localparam logic [3:0] PHASE_MAX = 4'd15;

    typedef struct packed {
        logic                 rd;
        logic                 wr;
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           wdata;
    } mem_req_t;

    typedef struct packed {
        logic [7:0] miso;
        logic       from_mem;
        logic       latch;
        logic       asleep;
    } step_t;

    // id byte k of the identification sequence
    function automatic logic [7:0] id_byte(input logic [63:0] first, input logic [7:0] last,
                                           input logic [3:0] k);
        logic [7:0] res;
        if (32'(k) >= ID_LENGTH || k > 4'd8)
            res = IDLE_BYTE;
        else if (k == 4'd8)
            res = last;
        else
            res = first[(3'd7 - k[2:0]) * 8 +: 8];
        return res;
    endfunction

endpackage

### rtl/core/sfce_cmd_if.sv
// word channel interfaces for command items and response items
`timescale 1ns / 1ps
interface sfce_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] mosi_byte;

    modport source (output valid, output mode, output mosi_byte, input ready);
    modport sink (input valid, input mode, input mosi_byte, output ready);
endinterface

interface sfce_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] miso_byte;
    logic       write_latch;
    logic       asleep;

    modport source (output valid, output miso_byte, output write_latch, output asleep,
                    input ready);
    modport sink (input valid, input miso_byte, input write_latch, input asleep,
                  output ready);
endinterface

### rtl/core/sfce_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
module sfce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     rd,
    input  logic                     wr,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[addr] <= wdata;
        end
        if (rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/sfce_ctrl.sv
// frame decoder: opcode, phase, address pointer, latch, status and sleep state
`timescale 1ns / 1ps
module sfce_ctrl
    import sfce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [1:0]  mode,
    input  logic [7:0]  mosi_byte,
    input  logic [63:0] id_first,
    input  logic [7:0]  id_last,
    output mem_req_t    mem_req,
    output step_t       step
);

    logic [7:0]           opcode_reg, opcode_next;
    logic [3:0]           phase_reg, phase_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic                 latch_reg, latch_next;
    logic [7:0]           status_reg, status_next;
    logic                 sleep_reg, sleep_next;
    logic                 ignored_reg, ignored_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg <= '0;
            phase_reg <= '0;
            addr_reg <= '0;
            latch_reg <= 1'b0;
            status_reg <= '0;
            sleep_reg <= 1'b0;
            ignored_reg <= 1'b0;
        end
        else if (accept)
        begin
            opcode_reg <= opcode_next;
            phase_reg <= phase_next;
            addr_reg <= addr_next;
            latch_reg <= latch_next;
            status_reg <= status_next;
            sleep_reg <= sleep_next;
            ignored_reg <= ignored_next;
        end
    end

    logic        active;
    logic [15:0] addr_wide;
    logic [3:0]  id_k;

    assign active = !ignored_reg && !sleep_reg;
    assign addr_wide = 16'(addr_reg);
    assign id_k = phase_reg - 4'd1;

    always_comb
    begin
        opcode_next = opcode_reg;
        phase_next = phase_reg;
        addr_next = addr_reg;
        latch_next = latch_reg;
        status_next = status_reg;
        sleep_next = sleep_reg;
        ignored_next = ignored_reg;
        mem_req.rd = 1'b0;
        mem_req.wr = 1'b0;
        mem_req.addr = addr_reg;
        mem_req.wdata = mosi_byte;
        step.miso = IDLE_BYTE;
        step.from_mem = 1'b0;

        case (mode)
            MODE_CS_ASSERT:
            begin
                opcode_next = '0;
                phase_next = '0;
                sleep_next = 1'b0;
                // the frame right after wake-up is dropped
                ignored_next = sleep_reg;
            end
            MODE_XFER:
            begin
                if (active)
                begin
                    if (phase_reg != PHASE_MAX)
                    begin
                        phase_next = phase_reg + 4'd1;
                    end
                    if (phase_reg == 4'd0)
                    begin
                        opcode_next = mosi_byte;
                    end
                    else
                    begin
                        case (opcode_reg)
                            OP_RDSR:
                            begin
                                step.miso = (status_reg & STATUS_MASK) | {6'b0, latch_reg, 1'b0};
                            end
                            OP_WRSR:
                            begin
                                if (phase_reg == 4'd1 && latch_reg)
                                begin
                                    status_next = mosi_byte & STATUS_MASK;
                                end
                            end
                            OP_RDID:
                            begin
                                step.miso = id_byte(id_first, id_last, id_k);
                            end
                            OP_READ, OP_WRITE:
                            begin
                                if (phase_reg == 4'd1)
                                begin
                                    addr_next = ADDR_BITS'({mosi_byte, 8'h00});
                                end
                                else if (phase_reg == 4'd2)
                                begin
                                    addr_next = ADDR_BITS'(addr_wide | {8'h00, mosi_byte});
                                end
                                else
                                begin
                                    addr_next = addr_reg + ADDR_BITS'(1);
                                    if (opcode_reg == OP_READ)
                                    begin
                                        mem_req.rd = 1'b1;
                                        step.from_mem = 1'b1;
                                    end
                                    else
                                    begin
                                        mem_req.wr = latch_reg;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            MODE_CS_RELEASE:
            begin
                if (active && phase_reg != 4'd0)
                begin
                    case (opcode_reg)
                        OP_WREN:
                        begin
                            latch_next = 1'b1;
                        end
                        OP_WRDI, OP_WRITE, OP_WRSR:
                        begin
                            latch_next = 1'b0;
                        end
                        OP_SLEEP:
                        begin
                            sleep_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ignored_next = 1'b1;
                opcode_next = '0;
                phase_next = '0;
            end
            default:
            begin
            end
        endcase

        step.latch = latch_next;
        step.asleep = sleep_next;
    end

endmodule

### rtl/core/spi_fram_slave_command_engine_top.sv
// top level: config registers, frame decoder, fram array and response register
// latency: a response word is valid the cycle after its command word is accepted
// throughput: one command word per cycle if not stalled; the array read issued
//   at acceptance lands in the ram output register feeding the response directly
// the response register holds a stalled word while the next command waits
// reset clears frame state, latch, status, sleep and id registers at once;
//   the array itself has no reset and needs no clearing pass
`timescale 1ns / 1ps
module spi_fram_slave_command_engine_top
    import sfce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sfce_cmd_if.sink              cmd,
    sfce_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [63:0] id_first_reg;
    logic [7:0]  id_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_first_reg <= '0;
            id_last_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ID_FIRST:
                begin
                    id_first_reg <= cfg_wdata;
                end
                CFG_ID_LAST:
                begin
                    id_last_reg <= cfg_wdata[7:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    logic     accept;
    logic     pend_valid_reg;
    step_t    pend_reg;
    mem_req_t mem_req;
    step_t    step;
    logic [7:0] mem_rdata;

    assign cmd.ready = !pend_valid_reg || rsp.ready;
    assign accept = cmd.valid && cmd.ready;

    sfce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (cmd.mode),
        .mosi_byte (cmd.mosi_byte),
        .id_first  (id_first_reg),
        .id_last   (id_last_reg),
        .mem_req   (mem_req),
        .step      (step)
    );

    // ram requests only fire with an accepted word
    sfce_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .rd    (mem_req.rd && accept),
        .wr    (mem_req.wr && accept),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            pend_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= step;
        end
    end

    // ram output holds until the next accepted read, so a stalled word stays put
    assign rsp.valid = pend_valid_reg;
    assign rsp.miso_byte = pend_reg.from_mem ? mem_rdata : pend_reg.miso;
    assign rsp.write_latch = pend_reg.latch;
    assign rsp.asleep = pend_reg.asleep;

endmodule

### rtl/core/sfce_checker.sv
// port level checks for the command engine, bound to the top level
`timescale 1ns / 1ps
module sfce_checker
    import sfce_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [1:0] cmd_mode,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] rsp_miso_byte,
    input logic       rsp_write_latch,
    input logic       rsp_asleep
);

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_miso_byte)
            && $stable(rsp_write_latch) && $stable(rsp_asleep))
        else $error("stalled response word changed");

    // every accepted command shows its response on the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> rsp_valid)
        else $error("response missing after accepted command");

    // a waiting response blocks new commands
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !cmd_ready)
        else $error("command taken while response stalled");

    // chip select assert wakes the device and drives no data
    a_assert_wake: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_mode == MODE_CS_ASSERT
            |=> !rsp_asleep && rsp_miso_byte == IDLE_BYTE)
        else $error("chip select assert response wrong");

endmodule

bind spi_fram_slave_command_engine_top sfce_checker u_sfce_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .cmd_mode        (cmd.mode),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_miso_byte   (rsp.miso_byte),
    .rsp_write_latch (rsp.write_latch),
    .rsp_asleep      (rsp.asleep)
);

### bench/fram_reply_checker.sv
// watches command and response words, predicts each response and compares it
`timescale 1ns / 1ps
module fram_reply_checker
    import sfce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sfce_cmd_if                   cmd,
    sfce_rsp_if                   rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [7:0] miso_byte;
        logic       write_latch;
        logic       asleep;
    } fram_reply_t;

    fram_reply_t reply_q[$];

    logic [7:0]           fram_mem [0:MEM_DEPTH-1];
    logic [7:0]           frame_op;
    logic [3:0]           frame_pos;
    logic [ADDR_BITS-1:0] mem_ptr;
    logic                 wel;
    logic [7:0]           status_reg;
    logic                 sleeping;
    logic                 frame_dead;
    logic [63:0]          id_head;
    logic [7:0]           id_tail;

    task automatic predict_fram_reply(input logic [1:0] mode, input logic [7:0] b,
                                      output fram_reply_t r);
        logic [3:0]  pos;
        logic [71:0] id_all;
        int          k;
        r.miso_byte = IDLE_BYTE;
        case (mode)
            MODE_CS_ASSERT:
            begin
                frame_op = 8'h00;
                frame_pos = 4'd0;
                // the assert that wakes the device opens a dead frame
                frame_dead = sleeping;
                sleeping = 1'b0;
            end
            MODE_XFER:
            begin
                if (!frame_dead && !sleeping)
                begin
                    pos = frame_pos;
                    if (frame_pos != PHASE_MAX)
                        frame_pos = frame_pos + 4'd1;
                    if (pos == 4'd0)
                        frame_op = b;
                    else
                    begin
                        case (frame_op)
                            OP_RDSR:
                                r.miso_byte = (status_reg & STATUS_MASK) | {6'd0, wel, 1'b0};
                            OP_WRSR:
                                if (pos == 4'd1 && wel)
                                    status_reg = b & STATUS_MASK;
                            OP_RDID:
                            begin
                                k = int'(pos) - 1;
                                id_all = {id_head, id_tail};
                                if (k < ID_LENGTH)
                                    r.miso_byte = id_all[71 - 8 * k -: 8];
                            end
                            OP_READ, OP_WRITE:
                            begin
                                if (pos == 4'd1)
                                    mem_ptr = ADDR_BITS'({b, 8'h00});
                                else if (pos == 4'd2)
                                    mem_ptr = mem_ptr | ADDR_BITS'(b);
                                else
                                begin
                                    if (frame_op == OP_READ)
                                        r.miso_byte = fram_mem[mem_ptr];
                                    else if (wel)
                                        fram_mem[mem_ptr] = b;
                                    mem_ptr = mem_ptr + ADDR_BITS'(1);
                                end
                            end
                            default:
                                ;
                        endcase
                    end
                end
            end
            MODE_CS_RELEASE:
            begin
                if (!frame_dead && !sleeping && frame_pos != 4'd0)
                begin
                    case (frame_op)
                        OP_WREN:
                            wel = 1'b1;
                        OP_WRDI, OP_WRITE, OP_WRSR:
                            wel = 1'b0;
                        OP_SLEEP:
                            sleeping = 1'b1;
                        default:
                            ;
                    endcase
                end
                frame_dead = 1'b1;
                frame_op = 8'h00;
                frame_pos = 4'd0;
            end
            default:
                ;
        endcase
        r.write_latch = wel;
        r.asleep = sleeping;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        fram_reply_t want;
        fram_reply_t got;
        if (!rst_n)
        begin
            reply_q.delete();
            frame_op = 8'h00;
            frame_pos = 4'd0;
            mem_ptr = '0;
            wel = 1'b0;
            status_reg = 8'h00;
            sleeping = 1'b0;
            frame_dead = 1'b0;
            id_head = 64'd0;
            id_tail = 8'd0;
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ID_FIRST)
                    id_head = cfg_wdata;
                else if (cfg_index == CFG_ID_LAST)
                    id_tail = cfg_wdata[7:0];
            end
            // a response word always belongs to an earlier command word
            if (rsp.valid && rsp.ready)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("unexpected response word: miso_byte %h", rsp.miso_byte);
                    fail_count++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    got.miso_byte = rsp.miso_byte;
                    got.write_latch = rsp.write_latch;
                    got.asleep = rsp.asleep;
                    if (got.miso_byte !== want.miso_byte)
                    begin
                        $error("miso_byte: expected %h, actual %h", want.miso_byte,
                               got.miso_byte);
                        fail_count++;
                    end
                    if (got.write_latch !== want.write_latch)
                    begin
                        $error("write_latch: expected %b, actual %b", want.write_latch,
                               got.write_latch);
                        fail_count++;
                    end
                    if (got.asleep !== want.asleep)
                    begin
                        $error("asleep: expected %b, actual %b", want.asleep, got.asleep);
                        fail_count++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                predict_fram_reply(cmd.mode, cmd.mosi_byte, want);
                reply_q.push_back(want);
            end
            pending = reply_q.size();
        end
    end

endmodule

### bench/tb_top.sv
// clock, reset, command stimulus, response stalls and verdict for the fram engine
`timescale 1ns / 1ps
module tb_top
    import sfce_pkg::*;
();

    localparam int MAX_GAP = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_WORDS = 300;
    localparam int NUM_SETTINGS = 5;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // written window that wraps over the top of the array
    localparam logic [15:0] FILL_BASE = 16'hFF80;
    localparam int FILL_WORDS = 256;
    localparam int READ_SPAN = 192;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count;
    int                    pending;
    int                    words_sent;
    int                    idle_cycles = 0;
    bit                    fast_mode;
    bit                    tx_burst;
    bit                    rx_burst;
    bit                    rx_hold;

    sfce_cmd_if cmd_ch();
    sfce_rsp_if rsp_ch();

    spi_fram_slave_command_engine_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fram_reply_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // every task below is entered and left at a falling edge
    task automatic send_word(input logic [1:0] mode, input logic [7:0] data);
        int gap;
        if ($urandom_range(0, 24) == 0)
            tx_burst = ~tx_burst;
        gap = (fast_mode || tx_burst) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.mode <= mode;
        cmd_ch.mosi_byte <= data;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic fram_frame(input logic [7:0] op, input int len, input logic [15:0] addr,
                              input bit clean);
        int addr_words;
        addr_words = (op == OP_READ || op == OP_WRITE) ? 2 : 0;
        // write frame cut short inside the address
        if (!clean && op == OP_WRITE && $urandom_range(0, 15) == 0)
            addr_words = $urandom_range(0, 1);
        send_word(MODE_CS_ASSERT, 8'($urandom));
        send_word(MODE_XFER, op);
        if (addr_words > 0)
            send_word(MODE_XFER, addr[15:8]);
        if (addr_words > 1)
            send_word(MODE_XFER, addr[7:0]);
        for (int i = 0; i < len; i++)
            send_word(MODE_XFER, 8'($urandom));
        // now and then the frame stays open and the next assert restarts it
        if (clean || $urandom_range(0, 11) != 0)
            send_word(MODE_CS_RELEASE, 8'($urandom));
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic load_id(input logic [63:0] head, input logic [7:0] tail);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ID_FIRST;
        cfg_wdata <= head;
        @(negedge clk);
        cfg_index <= CFG_ID_LAST;
        cfg_wdata <= {56'd0, tail};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        int          start;
        int          pick;
        int          len;
        logic [15:0] addr;
        start = words_sent;
        while (words_sent - start < count)
        begin
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
            // addresses stay inside the written window with room for a long burst
            addr = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                               : FILL_BASE + 16'($urandom_range(0, READ_SPAN - 1));
            if (pick < 20)
            begin
                fram_frame(OP_WREN, 0, addr, 1'b0);
                fram_frame(OP_WRITE, len, addr, 1'b0);
            end
            else if (pick < 35)
                fram_frame(OP_READ, len, addr, 1'b0);
            else if (pick < 42)
                fram_frame(OP_RDSR, $urandom_range(1, 3), addr, 1'b0);
            else if (pick < 47)
            begin
                fram_frame(OP_WREN, 0, addr, 1'b0);
                fram_frame(OP_WRSR, $urandom_range(1, 2), addr, 1'b0);
            end
            else if (pick < 52)
                fram_frame(OP_WRSR, 1, addr, 1'b0);
            else if (pick < 57)
                fram_frame(OP_WRITE, len, addr, 1'b0);
            else if (pick < 62)
                fram_frame(OP_WRDI, $urandom_range(0, 1), addr, 1'b0);
            else if (pick < 67)
                fram_frame(OP_WREN, $urandom_range(0, 1), addr, 1'b0);
            else if (pick < 74)
                fram_frame(OP_RDID, $urandom_range(0, 17), addr, 1'b0);
            else if (pick < 79)
            begin
                // sleep, stray words while asleep, then the ignored wake frame
                fram_frame(OP_SLEEP, 0, addr, 1'b0);
                repeat ($urandom_range(0, 2))
                    send_word(MODE_XFER, 8'($urandom));
                fram_frame($urandom_range(0, 1) ? OP_WREN : 8'($urandom), len, addr, 1'b0);
            end
            else if (pick < 86)
                fram_frame(8'($urandom), len, addr, 1'b0);
            else
            begin
                case ($urandom_range(0, 2))
                    0:
                        send_word(MODE_UNUSED, 8'($urandom));
                    1:
                        send_word(2'($urandom), 8'($urandom));
                    default:
                        send_word(MODE_XFER, 8'($urandom));
                endcase
            end
        end
    endtask

    initial
    begin : rx_side
        int gap;
        rsp_ch.ready = 1'b0;
        rx_burst = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 24) == 0)
                rx_burst = ~rx_burst;
            gap = (fast_mode || rx_burst) ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_hold)
            begin
                gap = HOLD_CYCLES;
                rx_hold = 1'b0;
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        logic [63:0] head [NUM_SETTINGS];
        logic [7:0]  tail [NUM_SETTINGS];
        cmd_ch.valid = 1'b0;
        cmd_ch.mode = MODE_CS_ASSERT;
        cmd_ch.mosi_byte = 8'h00;
        cfg_we = 1'b0;
        cfg_index = CFG_ID_FIRST;
        cfg_wdata = '0;
        rst_n = 1'b0;
        fast_mode = 1'b0;
        tx_burst = 1'b0;
        rx_hold = 1'b0;
        words_sent = 0;
        head[0] = {$urandom, $urandom};
        tail[0] = 8'($urandom);
        head[1] = 64'd0;
        tail[1] = 8'h00;
        head[2] = {64{1'b1}};
        tail[2] = 8'hFF;
        head[3] = 64'h0123_4567_89AB_CDEF;
        tail[3] = 8'h5A;
        head[4] = {$urandom, $urandom};
        tail[4] = 8'($urandom);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        load_id(head[0], tail[0]);

        // straight after reset a word opens a frame without an assert
        send_word(MODE_XFER, OP_RDSR);
        send_word(MODE_XFER, 8'h00);
        send_word(MODE_CS_RELEASE, 8'hFF);
        // stray word outside any frame, then the undefined mode
        send_word(MODE_XFER, 8'hFF);
        send_word(MODE_UNUSED, 8'h00);
        fram_frame(OP_WREN, 0, 16'h0000, 1'b1);
        // status write keeps only the protect bits, the second data word is dropped
        send_word(MODE_CS_ASSERT, 8'h00);
        send_word(MODE_XFER, OP_WRSR);
        send_word(MODE_XFER, 8'hFF);
        send_word(MODE_XFER, 8'h00);
        send_word(MODE_CS_RELEASE, 8'h00);
        fram_frame(OP_RDSR, 2, 16'h0000, 1'b1);
        fram_frame(OP_SLEEP, 0, 16'h0000, 1'b1);
        send_word(MODE_XFER, OP_WREN);
        // wake frame is ignored, so the latch stays clear
        fram_frame(OP_WREN, 0, 16'h0000, 1'b1);
        fram_frame(OP_RDSR, 1, 16'h0000, 1'b1);

        // fill the window across the top of the array so every later read hits written data
        fast_mode = 1'b1;
        fram_frame(OP_WREN, 0, 16'h0000, 1'b1);
        fram_frame(OP_WRITE, FILL_WORDS, FILL_BASE, 1'b1);
        fast_mode = 1'b0;

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            if (s > 0)
            begin
                drain();
                load_id(head[s], tail[s]);
            end
            fram_frame(OP_RDID, 16, 16'h0000, 1'b1);
            fram_frame(OP_READ, 3, 16'hFFFE, 1'b1);
            // response side stops long enough for the command side to back up
            if (s == 2)
                rx_hold = 1'b1;
            random_traffic(RANDOM_WORDS / NUM_SETTINGS);
        end

        drain();
        repeat (5) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
